// ===== hdl/rgpc_pkg.sv =====
// shared types, constants and register codes of the ray ground point classifier
package rgpc_pkg;

   localparam int TAG_BITS       = 16;
   localparam int RADIUS_BITS    = 18;
   localparam int HEIGHT_BITS    = 16;
   localparam int SENSOR_BITS    = 13;
   localparam int SLOPE_BITS     = 20;
   localparam int MINH_BITS      = 13;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_BITS       = QCNT_BITS + 1;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 20;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SENSOR_HEIGHT     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOCAL_SLOPE       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GENERAL_SLOPE     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONCENTRIC_DIST   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_LOCAL_HEIGHT  = 3'd4;

   localparam logic [SENSOR_BITS-1:0] RST_SENSOR_HEIGHT    = 13'd1800;
   localparam logic [SLOPE_BITS-1:0]  RST_LOCAL_SLOPE      = 20'd9209;
   localparam logic [SLOPE_BITS-1:0]  RST_GENERAL_SLOPE    = 20'd5734;
   localparam logic [RADIUS_BITS-1:0] RST_CONCENTRIC_DIST  = 18'd100;
   localparam logic [MINH_BITS-1:0]   RST_MIN_LOCAL_HEIGHT = 13'd50;

   typedef struct packed {
      logic [SENSOR_BITS-1:0] sensor_height_mm;
      logic [SLOPE_BITS-1:0]  local_slope_tan;
      logic [SLOPE_BITS-1:0]  general_slope_tan;
      logic [RADIUS_BITS-1:0] concentric_distance_mm;
      logic [MINH_BITS-1:0]   min_local_height_mm;
   } cfg_type;

   typedef struct packed {
      logic                ray_start;
      logic                local_ok;
      logic                general_ok;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   typedef struct packed {
      logic [QCNT_BITS-1:0] count;
      logic                 not_empty;
   } q_status_type;

endpackage

// ===== hdl/rgpc_front.sv =====
// front part: takes points, forms radius step and height windows, multiplies and compares
module rgpc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  rgpc_pkg::cfg_type                 cfg,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_ray_start,
   input  logic [rgpc_pkg::RADIUS_BITS-1:0]  req_radius_mm,
   input  logic signed [rgpc_pkg::HEIGHT_BITS-1:0] req_height_mm,
   input  logic [rgpc_pkg::TAG_BITS-1:0]     req_point_tag,
   input  rgpc_pkg::q_status_type            q_status,
   output logic                              push_valid,
   output rgpc_pkg::entry_type               push_word
);
   import rgpc_pkg::*;

   logic                     accept;
   logic [OCC_BITS-1:0]      occupancy;

   logic [RADIUS_BITS-1:0]   ray_radius_ff, ray_radius_in;
   logic [HEIGHT_BITS-1:0]   ray_height_ff, ray_height_in;

   logic [RADIUS_BITS-1:0]   base_radius;
   logic [HEIGHT_BITS-1:0]   base_height;

   logic                     a_valid_ff, a_valid_in;
   logic [RADIUS_BITS:0]     a_step_ff, a_step_in;
   logic [HEIGHT_BITS:0]     a_dh_ff, a_dh_in;
   logic [HEIGHT_BITS:0]     a_eh_ff, a_eh_in;
   logic [RADIUS_BITS-1:0]   a_radius_ff;
   logic                     a_beyond_ff, a_beyond_in;
   logic                     a_start_ff;
   logic [TAG_BITS-1:0]      a_tag_ff;

   logic                     b_valid_ff, b_valid_in;
   logic signed [39:0]       b_local_ff, b_local_in;
   logic [37:0]              b_gen_ff, b_gen_in;
   logic [HEIGHT_BITS:0]     b_dh_ff;
   logic [HEIGHT_BITS:0]     b_eh_ff;
   logic                     b_beyond_ff;
   logic                     b_start_ff;
   logic [TAG_BITS-1:0]      b_tag_ff;

   logic signed [40:0]       min_q;
   logic signed [40:0]       local_ext;
   logic signed [40:0]       local_thr;
   logic signed [40:0]       local_neg;
   logic signed [40:0]       d_q;
   logic signed [40:0]       gen_ext;
   logic signed [40:0]       gen_neg;
   logic signed [40:0]       e_q;

   // credit check against the queue, counting points still in flight
   assign occupancy = {1'b0, q_status.count} + OCC_BITS'(a_valid_ff) + OCC_BITS'(b_valid_ff);
   assign req_stall = (occupancy >= OCC_BITS'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // stage a: differences against the previous point of the ray
   always_comb begin
      base_radius    = req_ray_start ? '0 : ray_radius_ff;
      base_height    = req_ray_start ? (HEIGHT_BITS'(0) - HEIGHT_BITS'(cfg.sensor_height_mm))
                                     : ray_height_ff;
      a_step_in      = {1'b0, req_radius_mm} - {1'b0, base_radius};
      a_dh_in        = {req_height_mm[HEIGHT_BITS-1], req_height_mm}
                       - {base_height[HEIGHT_BITS-1], base_height};
      a_eh_in        = {req_height_mm[HEIGHT_BITS-1], req_height_mm}
                       + (HEIGHT_BITS+1)'(cfg.sensor_height_mm);
      a_beyond_in    = (req_radius_mm > cfg.concentric_distance_mm);
      a_valid_in     = accept;
      ray_radius_in  = accept ? req_radius_mm : ray_radius_ff;
      ray_height_in  = accept ? req_height_mm : ray_height_ff;
   end

   // stage b: threshold products
   always_comb begin
      b_valid_in = a_valid_ff;
      b_local_in = 40'($signed({1'b0, cfg.local_slope_tan})) * 40'($signed(a_step_ff));
      b_gen_in   = 38'(cfg.general_slope_tan) * 38'(a_radius_ff);
   end

   // window compares in Q16 millimetres
   always_comb begin
      min_q     = $signed({12'b0, cfg.min_local_height_mm, 16'b0});
      local_ext = $signed({b_local_ff[39], b_local_ff});
      local_thr = (b_beyond_ff && (local_ext < min_q)) ? min_q : local_ext;
      local_neg = -local_thr;
      d_q       = $signed({{8{b_dh_ff[HEIGHT_BITS]}}, b_dh_ff, 16'b0});
      gen_ext   = $signed({3'b0, b_gen_ff});
      gen_neg   = -gen_ext;
      e_q       = $signed({{8{b_eh_ff[HEIGHT_BITS]}}, b_eh_ff, 16'b0});

      push_valid           = b_valid_ff;
      push_word.ray_start  = b_start_ff;
      push_word.local_ok   = (d_q <= local_thr) && (d_q >= local_neg);
      push_word.general_ok = (e_q <= gen_ext) && (e_q >= gen_neg);
      push_word.tag        = b_tag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         ray_radius_ff <= '0;
         ray_height_ff <= '0;
      end else begin
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         ray_radius_ff <= ray_radius_in;
         ray_height_ff <= ray_height_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_step_ff   <= a_step_in;
         a_dh_ff     <= a_dh_in;
         a_eh_ff     <= a_eh_in;
         a_radius_ff <= req_radius_mm;
         a_beyond_ff <= a_beyond_in;
         a_start_ff  <= req_ray_start;
         a_tag_ff    <= req_point_tag;
      end
      if (a_valid_ff) begin
         b_local_ff  <= b_local_in;
         b_gen_ff    <= b_gen_in;
         b_dh_ff     <= a_dh_ff;
         b_eh_ff     <= a_eh_ff;
         b_beyond_ff <= a_beyond_ff;
         b_start_ff  <= a_start_ff;
         b_tag_ff    <= a_tag_ff;
      end
   end

endmodule

// ===== hdl/rgpc_queue.sv =====
// short queue of classified words between front and back parts
module rgpc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  rgpc_pkg::entry_type     push_word,
   input  logic                    pop,
   output rgpc_pkg::entry_type     head_word,
   output rgpc_pkg::q_status_type  q_status
);
   import rgpc_pkg::*;

   entry_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push_valid) - QCNT_BITS'(pop);
      head_word          = entries_ff[rd_ptr_ff];
      q_status.count     = count_ff;
      q_status.not_empty = (count_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== hdl/rgpc_back.sv =====
// back part: applies the ground chain along the ray and holds the result word
module rgpc_back (
   input  logic                           clock,
   input  logic                           reset,
   input  rgpc_pkg::entry_type            head_word,
   input  rgpc_pkg::q_status_type         q_status,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_is_ground,
   output logic [rgpc_pkg::TAG_BITS-1:0]  rsp_result_tag
);
   import rgpc_pkg::*;

   logic                  last_ground_ff, last_ground_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ground_ff;
   logic [TAG_BITS-1:0]   rsp_tag_ff;
   logic                  ground;

   always_comb begin
      pop    = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);
      ground = head_word.local_ok
               && ((!head_word.ray_start && last_ground_ff) || head_word.general_ok);
      last_ground_in = pop ? ground : last_ground_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ground_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         last_ground_ff <= last_ground_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ground_ff <= ground;
         rsp_tag_ff    <= head_word.tag;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_ground  = rsp_ground_ff;
   assign rsp_result_tag = rsp_tag_ff;

endmodule

// ===== hdl/ray_ground_point_classifier.sv =====
// top level of the ray ground point classifier: registers, front, queue and back parts
//
// points enter on the req_ channel, one word per point, sorted by radius within a ray,
// with req_ray_start marking the first point of each ray. one word leaves on the rsp_
// channel per point, in order, carrying the ground flag and the point tag.
// a word is taken at a clock edge where valid is high and stall is low.
// an accepted point passes the difference stage, the multiply stage, the compare into the
// queue and the result register in that order; a receiver stall can hold it in the queue.
// throughput: one point per cycle while rsp_stall stays low; the one-bit ground chain
// in the back part and the four-entry queue credit set that figure.
// the csr_ port writes one register per cycle by index; write only while idle.
// reset (synchronous, active high) restores register defaults, empties the pipeline
// and queue, and clears the previous point to radius 0, height 0, not ground.
// when the receiver stalls, the result word holds, the queue fills, and req_stall
// rises once the queue and the in-flight points reach the queue depth.
module ray_ground_point_classifier (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic [rgpc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [rgpc_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_ray_start,
   input  logic [rgpc_pkg::RADIUS_BITS-1:0]        req_radius_mm,
   input  logic signed [rgpc_pkg::HEIGHT_BITS-1:0] req_height_mm,
   input  logic [rgpc_pkg::TAG_BITS-1:0]           req_point_tag,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_is_ground,
   output logic [rgpc_pkg::TAG_BITS-1:0]           rsp_result_tag
);
   import rgpc_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   logic           push_valid;
   entry_type      push_word;
   entry_type      head_word;
   q_status_type   q_status;
   logic           pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SENSOR_HEIGHT: begin
               cfg_in.sensor_height_mm = csr_wdata[SENSOR_BITS-1:0];
            end
            CSR_LOCAL_SLOPE: begin
               cfg_in.local_slope_tan = csr_wdata[SLOPE_BITS-1:0];
            end
            CSR_GENERAL_SLOPE: begin
               cfg_in.general_slope_tan = csr_wdata[SLOPE_BITS-1:0];
            end
            CSR_CONCENTRIC_DIST: begin
               cfg_in.concentric_distance_mm = csr_wdata[RADIUS_BITS-1:0];
            end
            CSR_MIN_LOCAL_HEIGHT: begin
               cfg_in.min_local_height_mm = csr_wdata[MINH_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_height_mm       <= RST_SENSOR_HEIGHT;
         cfg_ff.local_slope_tan        <= RST_LOCAL_SLOPE;
         cfg_ff.general_slope_tan      <= RST_GENERAL_SLOPE;
         cfg_ff.concentric_distance_mm <= RST_CONCENTRIC_DIST;
         cfg_ff.min_local_height_mm    <= RST_MIN_LOCAL_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rgpc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ray_start (req_ray_start),
      .req_radius_mm (req_radius_mm),
      .req_height_mm (req_height_mm),
      .req_point_tag (req_point_tag),
      .q_status      (q_status),
      .push_valid    (push_valid),
      .push_word     (push_word)
   );

   rgpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .pop        (pop),
      .head_word  (head_word),
      .q_status   (q_status)
   );

   rgpc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_word      (head_word),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_ground  (rsp_is_ground),
      .rsp_result_tag (rsp_result_tag)
   );

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the ray ground point classifier
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rgpc_pkg::*;

   localparam int    CYCLE_LIMIT = 400000;
   localparam longint Q16_ONE    = 65536;
   localparam int    MAX_RADIUS  = 262143;

   typedef struct {
      logic                ground;
      logic [TAG_BITS-1:0] tag;
   } point_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_ray_start = 1'b0;
   logic [RADIUS_BITS-1:0]        req_radius_mm = '0;
   logic signed [HEIGHT_BITS-1:0] req_height_mm = '0;
   logic [TAG_BITS-1:0]           req_point_tag = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_is_ground;
   logic [TAG_BITS-1:0]           rsp_result_tag;

   cfg_type cfg_now = '{RST_SENSOR_HEIGHT, RST_LOCAL_SLOPE, RST_GENERAL_SLOPE,
                        RST_CONCENTRIC_DIST, RST_MIN_LOCAL_HEIGHT};
   logic [RADIUS_BITS-1:0]        model_radius = '0;
   logic signed [HEIGHT_BITS-1:0] model_height = '0;
   logic                          model_ground = 1'b0;

   point_result_type expected_results[$];

   bit tx_pace = 1'b1;
   bit rx_pace = 1'b1;
   int hold_len = 0;
   int hold_left = 0;
   int stall_left = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int points_sent = 0;
   int results_checked = 0;
   int grounds_seen = 0;
   int settings_loaded = 0;

   ray_ground_point_classifier dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ray_start  (req_ray_start),
      .req_radius_mm  (req_radius_mm),
      .req_height_mm  (req_height_mm),
      .req_point_tag  (req_point_tag),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_ground  (rsp_is_ground),
      .rsp_result_tag (rsp_result_tag)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_results.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic classify_point(input logic start,
                                           input logic [RADIUS_BITS-1:0] radius,
                                           input logic signed [HEIGHT_BITS-1:0] height);
      longint step;
      longint local_lim;
      longint floor_lim;
      longint general_lim;
      longint rise;
      longint above_floor;
      logic   ground;
      if (start) begin
         model_radius = '0;
         model_height = -$signed(HEIGHT_BITS'(cfg_now.sensor_height_mm));
         model_ground = 1'b0;
      end
      step      = longint'(radius) - longint'(model_radius);
      local_lim = longint'(cfg_now.local_slope_tan) * step;
      floor_lim = longint'(cfg_now.min_local_height_mm) * Q16_ONE;
      if (radius > cfg_now.concentric_distance_mm && local_lim < floor_lim) begin
         local_lim = floor_lim;
      end
      general_lim = longint'(cfg_now.general_slope_tan) * longint'(radius);
      rise        = (longint'(height) - longint'(model_height)) * Q16_ONE;
      ground      = 1'b0;
      if (rise <= local_lim && rise >= -local_lim) begin
         if (model_ground) begin
            ground = 1'b1;
         end else begin
            above_floor = (longint'(height) + longint'(cfg_now.sensor_height_mm)) * Q16_ONE;
            ground = (above_floor <= general_lim && above_floor >= -general_lim);
         end
      end
      model_radius = radius;
      model_height = height;
      model_ground = ground;
      return ground;
   endfunction

   function automatic int next_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (!tx_pace || pick < 55) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(10, 40);
      end
   endfunction

   // receiver: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_len > 0) begin
         hold_left = hold_len;
         hold_len  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (rx_pace && $urandom_range(0, 99) < 25) begin
         stall_left = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2)
                                                   : $urandom_range(20, 60);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      point_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result word with no point pending, tag %h", rsp_result_tag);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (want.ground) grounds_seen++;
            if (rsp_is_ground !== want.ground) begin
               $error("is_ground: expected %0b, actual %0b (tag %h)", want.ground,
                      rsp_is_ground, want.tag);
               mismatches++;
            end
            if (rsp_result_tag !== want.tag) begin
               $error("result_tag: expected %h, actual %h", want.tag, rsp_result_tag);
               mismatches++;
            end
         end
      end
   end

   task automatic send_point(input logic start, input logic [RADIUS_BITS-1:0] radius,
                             input logic signed [HEIGHT_BITS-1:0] height,
                             input logic [TAG_BITS-1:0] tag);
      int               gap;
      point_result_type want;
      gap = next_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_ray_start <= start;
      req_radius_mm <= radius;
      req_height_mm <= height;
      req_point_tag <= tag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want.ground = classify_point(start, radius, height);
      want.tag    = tag;
      expected_results.insert(expected_results.size(), want);
      points_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_SENSOR_HEIGHT:    cfg_now.sensor_height_mm       = data[SENSOR_BITS-1:0];
         CSR_LOCAL_SLOPE:      cfg_now.local_slope_tan        = data[SLOPE_BITS-1:0];
         CSR_GENERAL_SLOPE:    cfg_now.general_slope_tan      = data[SLOPE_BITS-1:0];
         CSR_CONCENTRIC_DIST:  cfg_now.concentric_distance_mm = data[RADIUS_BITS-1:0];
         CSR_MIN_LOCAL_HEIGHT: cfg_now.min_local_height_mm    = data[MINH_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_settings(input logic [CSR_DATA_BITS-1:0] sensor,
                                input logic [CSR_DATA_BITS-1:0] local_tan,
                                input logic [CSR_DATA_BITS-1:0] general_tan,
                                input logic [CSR_DATA_BITS-1:0] concentric,
                                input logic [CSR_DATA_BITS-1:0] min_height);
      wait_idle();
      csr_write(CSR_SENSOR_HEIGHT, sensor);
      csr_write(CSR_LOCAL_SLOPE, local_tan);
      csr_write(CSR_GENERAL_SLOPE, general_tan);
      csr_write(CSR_CONCENTRIC_DIST, concentric);
      csr_write(CSR_MIN_LOCAL_HEIGHT, min_height);
      // unused indexes must leave every register alone
      for (int i = int'(CSR_MIN_LOCAL_HEIGHT) + 1; i < 2 ** CSR_INDEX_BITS; i++) begin
         csr_write(CSR_INDEX_BITS'(i), CSR_DATA_BITS'($urandom));
      end
      settings_loaded++;
   endtask

   task automatic send_noise();
      send_point(1'($urandom), RADIUS_BITS'($urandom), HEIGHT_BITS'($urandom),
                 TAG_BITS'($urandom));
   endtask

   // one ray rising in radius, mostly near the ground plane, with obstacles and reversals
   task automatic send_ray(input int count);
      int r;
      int h;
      r = $urandom_range(0, 500);
      h = -int'(cfg_now.sensor_height_mm) + int'($urandom_range(0, 20)) - 10;
      for (int i = 0; i < count; i++) begin
         if (i > 0) begin
            if ($urandom_range(0, 9) == 0) r -= int'($urandom_range(0, 300));
            else r += int'($urandom_range(0, 400));
            case ($urandom_range(0, 9))
               0, 1:    h += int'($urandom_range(50, 1500));
               2:       h -= int'($urandom_range(50, 500));
               default: h += int'($urandom_range(0, 10)) - 5;
            endcase
         end
         if (r < 0) r = 0;
         if (r > MAX_RADIUS) r = MAX_RADIUS;
         if (h < -32768) h = -32768;
         if (h > 32767) h = 32767;
         send_point(i == 0, RADIUS_BITS'(r), HEIGHT_BITS'(h), TAG_BITS'($urandom));
      end
   endtask

   task automatic test_directed_points();
      // first point after reset has no ray start and sees height 0
      send_point(1'b0, 18'd50, 16'sd0, 16'h0000);
      send_point(1'b1, 18'd0, -16'sd1800, 16'h0001);
      send_point(1'b0, 18'd1000, -16'sd1790, 16'h0002);
      // radius falls but stays beyond the concentric distance
      send_point(1'b0, 18'd900, -16'sd1790, 16'h0003);
      // radius falls inside the concentric distance
      send_point(1'b0, 18'd60, -16'sd1790, 16'h0004);
      send_point(1'b1, 18'h3FFFF, 16'sh7FFF, 16'hFFFF);
      send_point(1'b0, 18'h3FFFF, 16'sh8000, 16'hAAAA);
      send_point(1'b1, 18'd80, -16'sd1800, 16'h5555);
      send_point(1'b0, 18'd60, -16'sd1800, 16'h00FF);
      send_point(1'b0, 18'd0, -16'sd1800, 16'hFF00);
      send_point(1'b1, 18'd200, -16'sd1700, 16'h1234);
      send_point(1'b0, 18'd400, -16'sd1690, 16'h4321);
      send_point(1'b0, 18'd101, -16'sd1690, 16'h0F0F);
      send_point(1'b1, 18'h2AAAA, 16'sh5555, 16'hF0F0);
      send_point(1'b0, 18'h15555, -16'sh5556, 16'h8001);
   endtask

   task automatic test_register_extremes();
      load_settings('0, '0, '0, '0, '0);
      send_ray(6);
      send_noise();
      load_settings(20'd8191, 20'hFFFFF, 20'hFFFFF, 20'h3FFFF, 20'd8191);
      send_ray(6);
      send_noise();
      // data bits above each register's width are dropped
      load_settings(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      send_ray(6);
      send_noise();
      load_settings(CSR_DATA_BITS'(RST_SENSOR_HEIGHT), CSR_DATA_BITS'(RST_LOCAL_SLOPE),
                    CSR_DATA_BITS'(RST_GENERAL_SLOPE), CSR_DATA_BITS'(RST_CONCENTRIC_DIST),
                    CSR_DATA_BITS'(RST_MIN_LOCAL_HEIGHT));
   endtask

   task automatic test_random_rays();
      int phase_start;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: ;
            4: load_settings(CSR_DATA_BITS'($urandom_range(0, 8191)),
                             CSR_DATA_BITS'($urandom_range(0, 20'hFFFFF)),
                             CSR_DATA_BITS'($urandom_range(0, 20'hFFFFF)),
                             20'd0, 20'd8191);
            default: load_settings(CSR_DATA_BITS'($urandom_range(300, 2500)),
                                   CSR_DATA_BITS'($urandom_range(3000, 40000)),
                                   CSR_DATA_BITS'($urandom_range(2000, 20000)),
                                   CSR_DATA_BITS'($urandom_range(0, 3000)),
                                   CSR_DATA_BITS'($urandom_range(0, 300)));
         endcase
         phase_start = points_sent;
         while (points_sent - phase_start < 90) begin
            if ($urandom_range(0, 4) == 0) send_noise();
            else send_ray($urandom_range(3, 14));
         end
      end
   endtask

   task automatic test_receiver_hold_off();
      wait_idle();
      tx_pace = 1'b0;
      @(posedge clock);
      hold_len = 150;
      send_ray(12);
      send_ray(12);
      // sender waits here for every result before going on
      wait_idle();
      tx_pace = 1'b1;
   endtask

   task automatic test_back_to_back();
      wait_idle();
      tx_pace = 1'b0;
      rx_pace = 1'b0;
      send_ray(15);
      send_ray(15);
      send_ray(15);
      wait_idle();
      tx_pace = 1'b1;
      rx_pace = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_points();
      test_register_extremes();
      test_random_rays();
      test_receiver_hold_off();
      test_back_to_back();
      wait_idle();
      repeat (8) @(posedge clock);
      $display("sent %0d points across %0d register settings, with hold-off and streaming",
               points_sent, settings_loaded);
      $display("checked %0d result words, %0d classed as ground", results_checked,
               grounds_seen);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/rgpc_pkg.sv
hdl/rgpc_front.sv
hdl/rgpc_queue.sv
hdl/rgpc_back.sv
hdl/ray_ground_point_classifier.sv
verif/testbench.sv
